// File: rtl/tdpt_pkg.sv
// Package: shared state and divisor-select codes for the trial-division prime tester.
`timescale 1ns / 1ps
`default_nettype none
package tdpt_pkg;

  typedef logic [1:0] state_t;
  localparam state_t ST_IDLE = 2'd0;  // wait for a transaction
  localparam state_t ST_DIV  = 2'd1;  // bit-serial remainder in progress
  localparam state_t ST_CHK  = 2'd2;  // inspect remainder, pick next divisor
  localparam state_t ST_BND  = 2'd3;  // square bound compare for the next pair

  typedef logic [1:0] dsel_t;
  localparam dsel_t SEL_TWO   = 2'd0;
  localparam dsel_t SEL_THREE = 2'd1;
  localparam dsel_t SEL_I     = 2'd2;
  localparam dsel_t SEL_I2    = 2'd3;

  localparam int unsigned FIRST_I  = 5;
  localparam int unsigned FIRST_SQ = 25;
  localparam int unsigned WHEEL    = 6;
  localparam int unsigned SQ_CONST = 36;  // WHEEL squared

endpackage
`default_nettype wire

// File: rtl/trial_division_prime_test_core.sv
// Top level: trial-division primality test on the 6k +/- 1 wheel, one remainder bit per cycle.
// Sequence: negative values and 0..3 strobe in the cycle after start. Others run a bit-serial
//   remainder and a check step per divisor (2, 3, then pairs i, i+2 while i*i <= n,
//   plus a bound step per pair): about 7700 pairs worst case at 32 bits.
// Throughput: one transaction at a time; busy stays high until the result strobe.
// Reset: synchronous active-low rst_n returns to idle and drops the strobe.
`timescale 1ns / 1ps
`default_nettype none
module trial_division_prime_test_core #(
  parameter int DATA_WIDTH = 32
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         start,
  output logic                        busy,
  input  wire signed [DATA_WIDTH-1:0] in_candidate,
  output logic                        out_valid,
  output logic                        out_is_prime
);

  localparam int W     = DATA_WIDTH;
  localparam int CNT_W = $clog2(W);

  tdpt_pkg::state_t state_r, state_nxt;
  tdpt_pkg::dsel_t  sel_r, sel_nxt;
  logic             valid_r, valid_nxt;
  logic             prime_r, prime_nxt;

  logic [W-1:0]     n_r, n_nxt;
  logic [W-1:0]     sh_r, sh_nxt;
  logic [W-1:0]     rem_r, rem_nxt;
  logic [W-1:0]     d_r, d_nxt;
  logic [W-1:0]     i_r, i_nxt;
  logic [W:0]       sq_r, sq_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [W:0]       rem_t;
  logic [W:0]       sq_step;
  logic [W-1:0]     cand_u;
  logic             accept;

  assign busy         = (state_r != tdpt_pkg::ST_IDLE);
  assign out_valid    = valid_r;
  assign out_is_prime = prime_r;
  assign accept       = start && !busy;
  assign cand_u       = in_candidate;

  assign rem_t   = {rem_r, sh_r[W-1]};
  // (i+6)^2 = i^2 + 12i + 36
  assign sq_step = {1'b0, i_r[W-4:0], 3'b000} + {1'b0, i_r[W-3:0], 2'b00}
                 + (W+1)'(tdpt_pkg::SQ_CONST);

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    valid_nxt = 1'b0;
    prime_nxt = prime_r;
    n_nxt     = n_r;
    sh_nxt    = sh_r;
    rem_nxt   = rem_r;
    d_nxt     = d_r;
    i_nxt     = i_r;
    sq_nxt    = sq_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      tdpt_pkg::ST_IDLE: begin
        if (accept) begin
          n_nxt   = cand_u;
          sh_nxt  = cand_u;
          rem_nxt = '0;
          cnt_nxt = '0;
          d_nxt   = W'(2);
          sel_nxt = tdpt_pkg::SEL_TWO;
          i_nxt   = W'(tdpt_pkg::FIRST_I);
          sq_nxt  = (W+1)'(tdpt_pkg::FIRST_SQ);
          if (cand_u[W-1] || cand_u <= W'(1)) begin
            valid_nxt = 1'b1;
            prime_nxt = 1'b0;
          end else if (cand_u <= W'(3)) begin
            valid_nxt = 1'b1;
            prime_nxt = 1'b1;
          end else begin
            state_nxt = tdpt_pkg::ST_DIV;
          end
        end
      end
      tdpt_pkg::ST_DIV: begin
        // restoring step: bring down one dividend bit
        if (rem_t >= {1'b0, d_r}) rem_nxt = W'(rem_t - {1'b0, d_r});
        else                      rem_nxt = rem_t[W-1:0];
        sh_nxt  = {sh_r[W-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(W-1)) state_nxt = tdpt_pkg::ST_CHK;
      end
      tdpt_pkg::ST_CHK: begin
        sh_nxt  = n_r;
        rem_nxt = '0;
        cnt_nxt = '0;
        if (rem_r == '0) begin
          valid_nxt = 1'b1;
          prime_nxt = 1'b0;
          state_nxt = tdpt_pkg::ST_IDLE;
        end else begin
          case (sel_r)
            tdpt_pkg::SEL_TWO: begin
              d_nxt     = W'(3);
              sel_nxt   = tdpt_pkg::SEL_THREE;
              state_nxt = tdpt_pkg::ST_DIV;
            end
            tdpt_pkg::SEL_THREE: state_nxt = tdpt_pkg::ST_BND;
            tdpt_pkg::SEL_I: begin
              d_nxt     = i_r + W'(2);
              sel_nxt   = tdpt_pkg::SEL_I2;
              state_nxt = tdpt_pkg::ST_DIV;
            end
            default: begin
              // advance to the next wheel pair
              i_nxt     = i_r + W'(tdpt_pkg::WHEEL);
              sq_nxt    = sq_r + sq_step;
              state_nxt = tdpt_pkg::ST_BND;
            end
          endcase
        end
      end
      default: begin
        if (sq_r > {1'b0, n_r}) begin
          valid_nxt = 1'b1;
          prime_nxt = 1'b1;
          state_nxt = tdpt_pkg::ST_IDLE;
        end else begin
          d_nxt     = i_r;
          sel_nxt   = tdpt_pkg::SEL_I;
          state_nxt = tdpt_pkg::ST_DIV;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tdpt_pkg::ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_r   <= sel_nxt;
    prime_r <= prime_nxt;
    n_r     <= n_nxt;
    sh_r    <= sh_nxt;
    rem_r   <= rem_nxt;
    d_r     <= d_nxt;
    i_r     <= i_nxt;
    sq_r    <= sq_nxt;
    cnt_r   <= cnt_nxt;
  end

endmodule
`default_nettype wire

// File: tb/sv/trial_division_prime_test_core_tb.sv
// Testbench for the trial-division prime tester: directed and random candidates vs. a wheel predictor.
`timescale 1ns / 1ps
module trial_division_prime_test_core_tb;

  localparam int CAND_W = 32;
  localparam int STALL_LIMIT = 2_000_000;
  localparam int DRAIN_CYCLES = 200;
  localparam int RANDOM_ITEMS = 76;
  localparam int MAX_RANDOM_PAIRS = 300;

  class prime_scoreboard;
    typedef struct {
      logic [CAND_W-1:0] candidate;
      bit                is_prime;
    } verdict_t;

    verdict_t awaited_verdicts[$];
    int failures = 0;

    // Trial division on the 6k +/- 1 wheel; pairs counts divisor pairs tried.
    static function bit wheel_verdict(logic [CAND_W-1:0] raw, output int pairs);
      longint unsigned n;
      longint unsigned d;
      pairs = 0;
      if (raw[CAND_W-1]) return 1'b0;
      n = raw;
      if (n <= 1) return 1'b0;
      if (n <= 3) return 1'b1;
      if (n % 2 == 0 || n % 3 == 0) return 1'b0;
      for (d = tdpt_pkg::FIRST_I; d <= n / d; d += tdpt_pkg::WHEEL) begin
        pairs++;
        if (n % d == 0 || n % (d + 2) == 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_candidate(logic [CAND_W-1:0] candidate);
      verdict_t v;
      int pairs;
      v.candidate = candidate;
      v.is_prime = wheel_verdict(candidate, pairs);
      awaited_verdicts = {awaited_verdicts, v};
    endfunction

    function void check_verdict(logic got);
      verdict_t want;
      if (awaited_verdicts.size() == 0) begin
        $display("%0t: unexpected result is_prime=%0b, expected none", $time, got);
        failures++;
        return;
      end
      want = awaited_verdicts.pop_front();
      if (got !== want.is_prime) begin
        $display("%0t: candidate %0d is_prime expected %0b actual %0b",
                 $time, $signed(want.candidate), want.is_prime, got);
        failures++;
      end
    endfunction

    function int awaited();
      return awaited_verdicts.size();
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic signed [CAND_W-1:0] in_candidate = '0;
  wire                      busy;
  wire                      out_valid;
  wire                      out_is_prime;

  int sender_idle_pct = 0;
  int stall_cycles = 0;
  prime_scoreboard sb = new();

  logic [CAND_W-1:0] directed_set[] = '{
    32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7, 32'd9, 32'd25, 32'd29,
    32'd35, 32'd49, 32'd121, 32'd143, 32'd169, 32'd1018081,
    32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFF9, 32'h8000_0000,
    32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h7FFF_FFFD
  };

  trial_division_prime_test_core #(
    .DATA_WIDTH(CAND_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_candidate(in_candidate),
    .out_valid(out_valid),
    .out_is_prime(out_is_prime)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Track transactions on both channels and run the stall watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_candidate(in_candidate);
      if (out_valid) sb.check_verdict(out_is_prime);
      if ((start && !busy) || out_valid) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  task automatic send_candidate(input logic [CAND_W-1:0] value);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_candidate <= value;
    do @(posedge clk); while (busy);
  endtask

  // Mostly small values; a few wide ones, kept cheap so the run stays short.
  function automatic logic [CAND_W-1:0] random_candidate();
    int unsigned pick;
    int unsigned p;
    int unsigned q;
    int pairs;
    logic [CAND_W-1:0] c;
    pick = $urandom_range(99);
    if (pick < 12) begin
      c = {1'b1, 31'($urandom)};
    end else if (pick < 60) begin
      c = $urandom_range(4095);
    end else if (pick < 75) begin
      c = $urandom_range(32'h3FFFF);
    end else if (pick < 90) begin
      // product of two wheel values reaches deep into the divisor loop
      p = tdpt_pkg::WHEEL * $urandom_range(1, 50) - 1 + 2 * $urandom_range(1);
      q = tdpt_pkg::WHEEL * $urandom_range(1, 50) - 1 + 2 * $urandom_range(1);
      c = p * q;
    end else begin
      c = {1'b0, 31'($urandom)};
      void'(prime_scoreboard::wheel_verdict(c, pairs));
      if (pairs > MAX_RANDOM_PAIRS) c[0] = 1'b0;
    end
    return c;
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    sender_idle_pct = 26;
    foreach (directed_set[i]) send_candidate(directed_set[i]);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) sender_idle_pct = 50;
      if (i == 2 * RANDOM_ITEMS / 3) sender_idle_pct = 0;
      send_candidate(random_candidate());
    end
    start <= 1'b0;

    while (sb.awaited() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
